### sv/lsms_pkg.sv
// Shared types and constants for the longitudinal spin magnitude step.
package lsms_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int DT_FRAC = 24;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THERMAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd2;

	localparam logic [31:0] DAMPING_RST = 32'd65536;
	localparam logic [31:0] THERMAL_RST = 32'd0;
	localparam logic [31:0] STEP_RST    = 32'd16777;

	localparam int SQRT_SPS = 4;
	localparam int DIV_SPS  = 4;

	localparam int TERM_W = 41;
	localparam logic [TERM_W-1:0] TERM_CAP = 41'h100_0000_0000;

	localparam int SCALE_W = 49;

	typedef struct packed {
		logic                busy;
		logic                e_nz;
		logic [63:0]         dtg;
		logic [SCALE_W-1:0]  scale;
	} lsms_cfg_t;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

### sv/longitudinal_spin_magnitude_step.sv
// Top level: longitudinal Langevin magnitude update, one spin per cycle.
// Takes one spin request per clock and registers its result through 2
// product/sum stages, 8 square-root stages, 16 divider stages, 3 multiply and
// scaling stages and 1 output register. A stalled output holds the whole pipeline.
// After reset and after every configuration write, in_ready stays low while
// dt*gamma is formed by a multiply and sqrt(2*gamma*E*dt) by the iterative
// root unit of the configuration block, one root bit per cycle.
module longitudinal_spin_magnitude_step import lsms_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_group,
	input  logic signed [31:0]   spin_x,
	input  logic signed [31:0]   spin_y,
	input  logic signed [31:0]   spin_z,
	input  logic signed [31:0]   field_x,
	input  logic signed [31:0]   field_y,
	input  logic signed [31:0]   field_z,
	input  logic signed [31:0]   long_noise,
	input  logic [31:0]          spin_magnitude,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          new_magnitude,
	output logic signed [31:0]   noise_used,
	output logic                 was_updated,
	output logic                 was_clamped
);
	localparam int DRIFT_SH = DT_FRAC + FRACTION_BITS;
	localparam int NOISE_SH = FRACTION_BITS + DT_FRAC / 2;
	localparam logic [31:0] FLOOR_RAW = 32'(((64'd1 << FRACTION_BITS) + 64'd50) / 64'd100);
	localparam int SQ_TW  = 32 + 32 + 1 + 1 + 64;
	localparam int DIV_TW = 32 + 32 + 1 + 1;

	lsms_cfg_t cfg;
	logic      en;

	lsms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign en       = !out_valid || out_ready;
	assign in_ready = en && !cfg.busy;

	// stage 1: component magnitudes and products
	logic [31:0] sv [3];
	logic [31:0] fv [3];
	logic [63:0] sq_s1 [3];
	logic [63:0] pp_s1 [3];
	logic        pn_s1 [3];
	logic [31:0] mag_s1, noise_s1;
	logic        grp_s1, v_s1;

	assign sv[0] = spin_x;
	assign sv[1] = spin_y;
	assign sv[2] = spin_z;
	assign fv[0] = field_x;
	assign fv[1] = field_y;
	assign fv[2] = field_z;

	for (genvar k = 0; k < 3; k++) begin : g_comp
		logic [31:0] sm, fm;
		assign sm = mag32(sv[k]);
		assign fm = mag32(fv[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s1[k] <= 64'(sm) * 64'(sm);
				pp_s1[k] <= 64'(sm) * 64'(fm);
				pn_s1[k] <= sv[k][31] ^ fv[k][31];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1   <= spin_magnitude;
			noise_s1 <= long_noise;
			grp_s1   <= in_group && ((spin_x | spin_y | spin_z) != 32'd0);
		end
	end

	// stage 2: sums
	logic [63:0] sq_s2, pos_s2, neg_s2;
	logic [31:0] mag_s2, noise_s2;
	logic        upd_s2, v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s2  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			pos_s2 <= (pn_s1[0] ? 64'd0 : pp_s1[0]) + (pn_s1[1] ? 64'd0 : pp_s1[1])
				+ (pn_s1[2] ? 64'd0 : pp_s1[2]);
			neg_s2 <= (pn_s1[0] ? pp_s1[0] : 64'd0) + (pn_s1[1] ? pp_s1[1] : 64'd0)
				+ (pn_s1[2] ? pp_s1[2] : 64'd0);
			mag_s2   <= mag_s1;
			noise_s2 <= noise_s1;
			upd_s2   <= grp_s1;
		end
	end

	logic        hneg;
	logic [63:0] dmag;
	assign hneg = neg_s2 > pos_s2;
	assign dmag = hneg ? (neg_s2 - pos_s2) : (pos_s2 - neg_s2);

	// norm and parallel field
	logic              sq_v;
	logic [31:0]       norm;
	logic [SQ_TW-1:0]  sq_tag;
	logic              dv_v;
	logic [63:0]       hpar;
	logic [DIV_TW-1:0] dv_tag;

	lsms_isqrt #(.XW(64), .SPS(SQRT_SPS), .TW(SQ_TW)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s2),
		.x       (sq_s2),
		.tag_in  ({mag_s2, noise_s2, upd_s2, hneg, dmag}),
		.out_v   (sq_v),
		.root    (norm),
		.tag_out (sq_tag)
	);

	lsms_div #(.NW(64), .DW(32), .SPS(DIV_SPS), .TW(DIV_TW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (sq_v),
		.num     (sq_tag[63:0]),
		.den     (norm),
		.tag_in  (sq_tag[SQ_TW-1:64]),
		.out_v   (dv_v),
		.quo     (hpar),
		.tag_out (dv_tag)
	);

	// m1: partial products
	logic [63:0] p00_m1, p01_m1, p10_m1, p11_m1, n0_m1;
	logic [48:0] n1_m1;
	logic [31:0] mag_m1, noise_m1;
	logic        upd_m1, hneg_m1, v_m1;
	logic [31:0] nmag;
	assign nmag = mag32(dv_tag[33:2]);

	always_ff @(posedge clk) begin
		if (en) begin
			p00_m1   <= 64'(cfg.dtg[31:0]) * 64'(hpar[31:0]);
			p01_m1   <= 64'(cfg.dtg[31:0]) * 64'(hpar[63:32]);
			p10_m1   <= 64'(cfg.dtg[63:32]) * 64'(hpar[31:0]);
			p11_m1   <= 64'(cfg.dtg[63:32]) * 64'(hpar[63:32]);
			n0_m1    <= 64'(cfg.scale[31:0]) * 64'(nmag);
			n1_m1    <= 49'(cfg.scale[SCALE_W-1:32]) * 49'(nmag);
			mag_m1   <= dv_tag[65:34];
			noise_m1 <= dv_tag[33:2];
			upd_m1   <= dv_tag[1];
			hneg_m1  <= dv_tag[0];
		end
	end

	// m2: assemble products
	logic [127:0] dp_m2;
	logic [80:0]  np_m2;
	logic [31:0]  mag_m2, noise_m2;
	logic         upd_m2, hneg_m2, v_m2;

	always_ff @(posedge clk) begin
		if (en) begin
			dp_m2 <= {p11_m1, p00_m1} + {32'd0, p01_m1, 32'd0} + {32'd0, p10_m1, 32'd0};
			np_m2 <= {17'd0, n0_m1} + {n1_m1, 32'd0};
			mag_m2   <= mag_m1;
			noise_m2 <= noise_m1;
			upd_m2   <= upd_m1;
			hneg_m2  <= hneg_m1;
		end
	end

	// m3: scale and cap
	logic [127:0]      dsh;
	logic [80:0]       nsh;
	logic [TERM_W-1:0] drift_m3, nterm_m3;
	logic [31:0]       mag_m3, noise_m3;
	logic              upd_m3, hneg_m3, v_m3;
	assign dsh = dp_m2 >> DRIFT_SH;
	assign nsh = np_m2 >> NOISE_SH;

	always_ff @(posedge clk) begin
		if (en) begin
			drift_m3 <= (dsh > 128'(TERM_CAP)) ? TERM_CAP : dsh[TERM_W-1:0];
			nterm_m3 <= (nsh > 81'(TERM_CAP)) ? TERM_CAP : nsh[TERM_W-1:0];
			mag_m3   <= mag_m2;
			noise_m3 <= noise_m2;
			upd_m3   <= upd_m2;
			hneg_m3  <= hneg_m2;
		end
	end

	// final sum, clamp, output register
	logic signed [43:0] dx, nx, sum;
	logic               below, above;
	assign dx    = 44'(drift_m3);
	assign nx    = 44'(nterm_m3);
	assign sum   = $signed({12'd0, mag_m3}) + (hneg_m3 ? -dx : dx)
		+ (noise_m3[31] ? -nx : nx);
	assign below = sum < $signed({12'd0, FLOOR_RAW});
	assign above = sum > $signed({12'd0, 32'hFFFF_FFFF});

	always_ff @(posedge clk) begin
		if (en) begin
			if (upd_m3) begin
				new_magnitude <= below ? FLOOR_RAW : (above ? 32'hFFFF_FFFF : sum[31:0]);
				noise_used    <= cfg.e_nz ? noise_m3 : 32'd0;
				was_updated   <= 1'b1;
				was_clamped   <= below;
			end else begin
				new_magnitude <= mag_m3;
				noise_used    <= 32'd0;
				was_updated   <= 1'b0;
				was_clamped   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_m1      <= 1'b0;
			v_m2      <= 1'b0;
			v_m3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid && in_ready;
			v_s2      <= v_s1;
			v_m1      <= dv_v;
			v_m2      <= v_m1;
			v_m3      <= v_m2;
			out_valid <= v_m3;
		end
	end
endmodule

### sv/lsms_isqrt.sv
// Pipelined digit-by-digit integer square root with sideband tag.
module lsms_isqrt import lsms_pkg::*; #(
	parameter int XW  = 64,
	parameter int SPS = SQRT_SPS,
	parameter int TW  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [XW-1:0] x,
	input  logic [TW-1:0] tag_in,
	output logic          out_v,
	output logic [XW/2-1:0] root,
	output logic [TW-1:0] tag_out
);
	localparam int RW  = XW / 2;
	localparam int NST = RW / SPS;

	logic [XW-1:0] x_s   [NST];
	logic [RW+2:0] rem_s [NST];
	logic [RW-1:0] q_s   [NST];
	logic [TW-1:0] tag_s [NST];
	logic          v_s   [NST];

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic [XW-1:0] xi;
		logic [RW+2:0] ri;
		logic [RW-1:0] qi;
		logic [TW-1:0] ti;
		logic          vi;
		logic [XW-1:0] xo;
		logic [RW+2:0] ro;
		logic [RW-1:0] qo;

		if (k == 0) begin : g_first
			assign xi = x;
			assign ri = '0;
			assign qi = '0;
			assign ti = tag_in;
			assign vi = in_v;
		end else begin : g_next
			assign xi = x_s[k-1];
			assign ri = rem_s[k-1];
			assign qi = q_s[k-1];
			assign ti = tag_s[k-1];
			assign vi = v_s[k-1];
		end

		always_comb begin
			logic [RW+2:0] trial;
			xo = xi;
			ro = ri;
			qo = qi;
			for (int j = 0; j < SPS; j++) begin
				ro = {ro[RW:0], xo[XW-1:XW-2]};
				xo = {xo[XW-3:0], 2'b00};
				trial = {1'b0, qo, 2'b01};
				if (ro >= trial) begin
					ro = ro - trial;
					qo = {qo[RW-2:0], 1'b1};
				end else begin
					qo = {qo[RW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]   <= xo;
				rem_s[k] <= ro;
				q_s[k]   <= qo;
				tag_s[k] <= ti;
			end
		end
	end

	assign out_v   = v_s[NST-1];
	assign root    = q_s[NST-1];
	assign tag_out = tag_s[NST-1];
endmodule

### sv/lsms_div.sv
// Pipelined restoring divider with sideband tag.
module lsms_div import lsms_pkg::*; #(
	parameter int NW  = 64,
	parameter int DW  = 32,
	parameter int SPS = DIV_SPS,
	parameter int TW  = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag_in,
	output logic          out_v,
	output logic [NW-1:0] quo,
	output logic [TW-1:0] tag_out
);
	localparam int NST = NW / SPS;

	logic [NW-1:0] n_s   [NST];
	logic [DW:0]   rem_s [NST];
	logic [DW-1:0] d_s   [NST];
	logic [TW-1:0] tag_s [NST];
	logic          v_s   [NST];

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic [NW-1:0] ni;
		logic [DW:0]   ri;
		logic [DW-1:0] di;
		logic [TW-1:0] ti;
		logic          vi;
		logic [NW-1:0] no;
		logic [DW:0]   ro;

		if (k == 0) begin : g_first
			assign ni = num;
			assign ri = '0;
			assign di = den;
			assign ti = tag_in;
			assign vi = in_v;
		end else begin : g_next
			assign ni = n_s[k-1];
			assign ri = rem_s[k-1];
			assign di = d_s[k-1];
			assign ti = tag_s[k-1];
			assign vi = v_s[k-1];
		end

		always_comb begin
			no = ni;
			ro = ri;
			for (int j = 0; j < SPS; j++) begin
				ro = {ro[DW-1:0], no[NW-1]};
				no = {no[NW-2:0], 1'b0};
				if (ro >= {1'b0, di}) begin
					ro = ro - {1'b0, di};
					no[0] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k]   <= no;
				rem_s[k] <= ro;
				d_s[k]   <= di;
				tag_s[k] <= ti;
			end
		end
	end

	assign out_v   = v_s[NST-1];
	assign quo     = n_s[NST-1];
	assign tag_out = tag_s[NST-1];
endmodule

### sv/lsms_cfg.sv
// Configuration registers and derived step constants (dt*gamma, noise scale).
module lsms_cfg import lsms_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output lsms_cfg_t            cfg
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_MUL3 = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;
	localparam logic [2:0] ST_ROOT = 3'd5;

	localparam int XW = 2 * SCALE_W;
	localparam logic [5:0] LAST_STEP = 6'(SCALE_W - 1);

	logic [2:0]         state_q;
	logic [31:0]        damp_q, therm_q, step_q;
	logic [63:0]        dtg_q, a_q, plo_q, phi_q;
	logic [XW-1:0]      x_q;
	logic [SCALE_W+2:0] rem_q;
	logic [SCALE_W-1:0] root_q;
	logic [5:0]         cnt_q;

	logic [SCALE_W+2:0] rem_sh, trial;
	logic [95:0]        prod96;

	assign rem_sh = {rem_q[SCALE_W:0], x_q[XW-1:XW-2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign prod96 = {phi_q, 32'd0} + {32'd0, plo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MUL1;
			damp_q  <= DAMPING_RST;
			therm_q <= THERMAL_RST;
			step_q  <= STEP_RST;
			cnt_q   <= '0;
		end else if (cfg_we) begin
			state_q <= ST_MUL1;
			case (cfg_index)
				CFG_DAMPING: damp_q  <= cfg_data;
				CFG_THERMAL: therm_q <= cfg_data;
				CFG_STEP:    step_q  <= cfg_data;
				default: ;
			endcase
		end else begin
			case (state_q)
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_SUM;
				ST_SUM: begin
					state_q <= ST_ROOT;
					cnt_q   <= '0;
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == LAST_STEP) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL1: begin
				dtg_q <= 64'(step_q) * 64'(damp_q);
				a_q   <= 64'(damp_q) * 64'(therm_q);
			end
			ST_MUL2: plo_q <= 64'(a_q[31:0]) * 64'(step_q);
			ST_MUL3: phi_q <= 64'(a_q[63:32]) * 64'(step_q);
			ST_SUM: begin
				x_q    <= {1'b0, prod96, 1'b0};
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_ROOT: begin
				x_q <= {x_q[XW-3:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[SCALE_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[SCALE_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign cfg.busy  = (state_q != ST_IDLE);
	assign cfg.e_nz  = (therm_q != 32'd0);
	assign cfg.dtg   = dtg_q;
	assign cfg.scale = root_q;
endmodule
